FILE: hdl/hs_pkg.sv
package hs_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned DataW = 32;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                    insert;
    logic                    shift;
    logic signed [DataW-1:0] value;
  } hs_cmd_t;

  // what a cell shows to its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    gt;
    logic signed [DataW-1:0] value;
  } hs_link_t;

endpackage

FILE: hdl/hs_cell.sv
module hs_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hs_pkg::hs_cmd_t  cmd_i,
  input  hs_pkg::hs_link_t left_i,
  input  hs_pkg::hs_link_t right_i,
  output hs_pkg::hs_link_t cell_o
);
  import hs_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [DataW-1:0] value_q, value_d;
  logic signed [DataW-1:0] cmd_value;
  logic                    gt;

  assign cmd_value = cmd_i.value;
  assign gt        = valid_q && (value_q > cmd_value);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.shift) begin
      // drain toward cell zero
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else if (cmd_i.insert) begin
      // a valid cell not above the new beat keeps its value
      if (!valid_q || gt) begin
        if (left_i.gt) begin
          valid_d = 1'b1;
          value_d = left_i.value;
        end else if (left_i.valid) begin
          valid_d = 1'b1;
          value_d = cmd_value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.gt    = gt;
  assign cell_o.value = value_q;

endmodule

FILE: hdl/heap_sorter.sv
// the first result comes in the cycle after the beat marked last is taken
// input is taken one beat per cycle while loading; a run then emits its kept elements,
//   up to DEPTH of them, as results in back-to-back cycles with busy high
// reset: rst_ni clears the occupancy of every cell and the drop flag at once
// the receiver cannot stall: each result strobe lasts exactly one cycle
module heap_sorter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [hs_pkg::DataW-1:0] value_i,
  input  logic                           last_i,
  output logic                           res_valid_o,
  output logic signed [hs_pkg::DataW-1:0] value_res_o,
  output logic                           last_res_o,
  output logic                           overflow_o
);
  import hs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e   state_q;
  logic     drop_q;
  logic     accept;
  logic     full;
  hs_cmd_t  cmd;
  hs_link_t link [DEPTH];
  hs_link_t edge_left;
  hs_link_t edge_right;

  assign accept = start && !busy;
  assign full   = link[DEPTH-1].valid;

  assign cmd.insert = accept && !full;
  assign cmd.shift  = (state_q == ST_EMIT);
  assign cmd.value  = value_i;

  // cell zero sees an occupied neighbor that is never above the new beat
  assign edge_left.valid  = 1'b1;
  assign edge_left.gt     = 1'b0;
  assign edge_left.value  = '0;
  assign edge_right.valid = 1'b0;
  assign edge_right.gt    = 1'b0;
  assign edge_right.value = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    hs_link_t left_in;
    hs_link_t right_in;
    if (i == 0) begin : g_first
      assign left_in = edge_left;
    end else begin : g_mid_l
      assign left_in = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign right_in = edge_right;
    end else begin : g_mid_r
      assign right_in = link[i+1];
    end
    hs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_in),
      .right_i (right_in),
      .cell_o  (link[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      drop_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && full) begin
            drop_q <= 1'b1;
          end
          if (accept && last_i) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (last_res_o) begin
            state_q <= ST_IDLE;
            drop_q  <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_q == ST_EMIT);
  assign res_valid_o = (state_q == ST_EMIT);
  assign value_res_o = link[0].value;
  assign last_res_o  = !link[1].valid;
  assign overflow_o  = drop_q;

endmodule

FILE: hdl/hs_checker.sv
module hs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_i,
  input logic res_valid_o,
  input logic last_res_o,
  input logic overflow_o
);

  // results only come out during a burst
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result strobe outside busy");

  // a last beat opens the burst in the next cycle
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> res_valid_o)
    else $error("no burst after last beat");

  // the burst has no gaps
  a_burst_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_res_o) |=> res_valid_o)
    else $error("gap inside burst");

  // the final result frees the block
  a_end_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_res_o) |=> !busy)
    else $error("busy after final result");

  // overflow holds one value through the whole burst of results
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_res_o) |=> (overflow_o == $past(overflow_o)))
    else $error("overflow changed within a run");

endmodule

bind heap_sorter hs_checker u_hs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .last_i      (last_i),
  .res_valid_o (res_valid_o),
  .last_res_o  (last_res_o),
  .overflow_o  (overflow_o)
);
